FILE: rtl/core/bm25_pkg.sv
// Shared types and constants for the BM25 score accumulator.
// Used by the controller, the datapath and the top level.
package bm25_pkg;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_DOCS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AVG_LEN    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_K1_GAIN    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_WEIGHT   = 8'd3;

	// Register reset values
	localparam logic [23:0] TOTAL_DOCS_RST = 24'd3213835;
	localparam logic [19:0] AVG_LEN_RST    = 20'd100;
	localparam logic [15:0] K1_GAIN_RST    = 16'd4915;
	localparam logic [16:0] B_WEIGHT_RST   = 17'd49152;

	// Arithmetic constants
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [16:0] K1_ONE_Q12  = 17'd4096;
	localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;

	// Step counts of the iterative units
	localparam int unsigned LOG_FRAC      = 24;
	localparam int unsigned LEN_DIV_STEPS = 20;
	localparam int unsigned TF_DIV_STEPS  = 29;
	localparam int unsigned CNT_W         = 5;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP,
		OP_LOG_INIT,
		OP_LOG_STEP,
		OP_LOG_SAVE,
		OP_MAG,
		OP_IDF,
		OP_LDIV_INIT,
		OP_DIV_STEP,
		OP_NORM,
		OP_DEN_MUL,
		OP_TDIV_INIT,
		OP_PROD,
		OP_ROUND,
		OP_ACC
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   log_sel;   // 0: numerator log, 1: denominator log
		logic   emit;      // move sum to output register and clear it
	} dp_cmd_t;

endpackage

FILE: rtl/core/bm25_ctrl.sv
// Sequencer for the BM25 score accumulator: steps the datapath per request
// and owns the request and result handshakes. Depends on bm25_pkg.
module bm25_ctrl
	import bm25_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    term_present,
	input  logic    last_term,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_PREP, S_LINIT, S_LSTEP, S_LSAVE, S_MAG, S_IDF,
		S_LDIV_INIT, S_LDIV, S_NORM, S_DENMUL, S_TDIV_INIT, S_TDIV,
		S_PROD, S_ROUND, S_ACC, S_FINISH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               sel_q;
	logic               last_q;
	logic               out_valid_q;
	logic               in_acc;
	logic               out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Decode the datapath command from the state
	always_comb begin
		cmd = '{op: OP_NONE, log_sel: sel_q, emit: 1'b0};
		unique case (state_q)
			S_IDLE:      cmd.op = in_acc ? OP_LOAD : OP_NONE;
			S_PREP:      cmd.op = OP_PREP;
			S_LINIT:     cmd.op = OP_LOG_INIT;
			S_LSTEP:     cmd.op = OP_LOG_STEP;
			S_LSAVE:     cmd.op = OP_LOG_SAVE;
			S_MAG:       cmd.op = OP_MAG;
			S_IDF:       cmd.op = OP_IDF;
			S_LDIV_INIT: cmd.op = OP_LDIV_INIT;
			S_LDIV:      cmd.op = OP_DIV_STEP;
			S_NORM:      cmd.op = OP_NORM;
			S_DENMUL:    cmd.op = OP_DEN_MUL;
			S_TDIV_INIT: cmd.op = OP_TDIV_INIT;
			S_TDIV:      cmd.op = OP_DIV_STEP;
			S_PROD:      cmd.op = OP_PROD;
			S_ROUND:     cmd.op = OP_ROUND;
			S_ACC:       cmd.op = OP_ACC;
			S_FINISH:    cmd.emit = out_free;
			default:     cmd.op = OP_NONE;
		endcase
	end

	// Hold state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result on emit, drop it once taken
			if (state_q == S_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						last_q <= last_term;
						if (term_present)
							state_q <= S_PREP;
						else if (last_term)
							state_q <= S_FINISH;
					end
				end
				S_PREP: begin
					sel_q   <= 1'b0;
					state_q <= S_LINIT;
				end
				S_LINIT: begin
					cnt_q   <= '0;
					state_q <= S_LSTEP;
				end
				S_LSTEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(LOG_FRAC - 1))
						state_q <= S_LSAVE;
				end
				S_LSAVE: begin
					sel_q   <= 1'b1;
					state_q <= sel_q ? S_MAG : S_LINIT;
				end
				S_MAG:       state_q <= S_IDF;
				S_IDF:       state_q <= S_LDIV_INIT;
				S_LDIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_LDIV;
				end
				S_LDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(LEN_DIV_STEPS - 1))
						state_q <= S_NORM;
				end
				S_NORM:      state_q <= S_DENMUL;
				S_DENMUL:    state_q <= S_TDIV_INIT;
				S_TDIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_TDIV;
				end
				S_TDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TF_DIV_STEPS - 1))
						state_q <= S_PROD;
				end
				S_PROD:  state_q <= S_ROUND;
				S_ROUND: state_q <= S_ACC;
				S_ACC:   state_q <= last_q ? S_FINISH : S_IDLE;
				S_FINISH: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/bm25_dpath.sv
// Datapath of the BM25 score accumulator: configuration registers, shared
// log2 squaring unit, shared restoring divider, multipliers and the
// saturating sum. Depends on bm25_pkg.
module bm25_dpath
	import bm25_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [15:0]           term_freq,
	input  logic [19:0]           doc_length,
	input  logic [23:0]           doc_freq,
	output logic signed [31:0]    total_score,
	output logic                  saturated
);

	localparam int unsigned SW = (FRAC_BITS + 12 > 34) ? FRAC_BITS + 12 : 34;
	localparam logic signed [SW-1:0] SUM_MAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SUM_MIN = -SUM_MAX - SW'(64'sd1);

	// Configuration registers
	logic [23:0] ndocs_q;
	logic [19:0] avg_q;
	logic [15:0] k1_q;
	logic [16:0] b_q;

	// Request operands
	logic [15:0] tf_q;
	logic [19:0] len_q;
	logic [23:0] df_q;

	// Log unit
	logic [24:0] num_q, den_q;
	logic [4:0]  e_q;
	logic [30:0] m_q;
	logic [23:0] frac_q;
	logic [28:0] ln_q, ld_q, mag_q;
	logic        neg_q;
	logic [27:0] idf_q;

	// Divider and tf part
	logic [53:0] rem_q, divisor_q;
	logic [28:0] dvd_q, quo_q;
	logic [36:0] bq_q;
	logic [52:0] kn_q;
	logic [32:0] nm_q;
	logic [56:0] prod_q;
	logic signed [SW-1:0] term_q;

	// Sum and result
	logic [31:0] sum_q;
	logic        ovf_q;
	logic [31:0] total_q;
	logic        sat_q;

	logic [23:0] dfc;
	logic [24:0] log_x;
	logic [4:0]  msb;
	logic [61:0] sq;
	logic [31:0] sq_t;
	logic [60:0] idf_full;
	logic [54:0] rem_sh;
	logic        q_bit;
	logic [16:0] bc;
	logic [36:0] norm;
	logic [28:0] quo_eff;
	logic [57:0] rnd;
	logic [SW-1:0] s_mag;
	logic signed [SW-1:0] acc_v;

	// Find the leading one of the log operand
	always_comb begin
		log_x = cmd.log_sel ? den_q : num_q;
		msb   = '0;
		for (int i = 0; i < 25; i++)
			if (log_x[i])
				msb = 5'(i);
	end

	assign dfc      = (df_q > ndocs_q) ? ndocs_q : df_q;
	assign sq       = 62'(m_q) * 62'(m_q);
	assign sq_t     = sq[61:30];
	assign idf_full = 61'(mag_q) * 61'(LOG10_2_Q32);
	assign rem_sh   = {rem_q, dvd_q[28]};
	assign q_bit    = rem_sh >= {1'b0, divisor_q};
	assign bc       = (b_q > ONE_Q16) ? ONE_Q16 : b_q;
	assign norm     = 37'(ONE_Q16 - bc) + bq_q;
	assign quo_eff  = (tf_q == '0) ? '0 : quo_q;
	assign rnd      = 58'(prod_q) + (58'd1 << (47 - FRAC_BITS));
	assign s_mag    = SW'(rnd >> (48 - FRAC_BITS));
	assign acc_v    = SW'(signed'(sum_q)) + term_q;

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndocs_q <= TOTAL_DOCS_RST;
			avg_q   <= AVG_LEN_RST;
			k1_q    <= K1_GAIN_RST;
			b_q     <= B_WEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_TOTAL_DOCS) ndocs_q <= cfg_data;
			if (cfg_index == REG_AVG_LEN)    avg_q   <= cfg_data[19:0];
			if (cfg_index == REG_K1_GAIN)    k1_q    <= cfg_data[15:0];
			if (cfg_index == REG_B_WEIGHT)   b_q     <= cfg_data[16:0];
		end
	end

	// Running sum, overflow flag and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.emit) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.op == OP_ACC) begin
			if (acc_v > SUM_MAX) begin
				sum_q <= 32'h7FFF_FFFF;
				ovf_q <= 1'b1;
			end else if (acc_v < SUM_MIN) begin
				sum_q <= 32'h8000_0000;
				ovf_q <= 1'b1;
			end else begin
				sum_q <= acc_v[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			total_q <= sum_q;
			sat_q   <= ovf_q;
		end
	end

	assign total_score = signed'(total_q);
	assign saturated   = sat_q;

	// Step the arithmetic per command
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_NONE: ;
			OP_LOAD: begin
				tf_q  <= term_freq;
				len_q <= doc_length;
				df_q  <= doc_freq;
			end
			OP_PREP: begin
				num_q <= {ndocs_q - dfc, 1'b1};
				den_q <= {dfc, 1'b1};
			end
			OP_LOG_INIT: begin
				e_q    <= msb;
				m_q    <= 31'(log_x) << (5'd30 - msb);
				frac_q <= '0;
			end
			OP_LOG_STEP: begin
				m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
				frac_q <= {frac_q[22:0], sq_t[31]};
			end
			OP_LOG_SAVE: begin
				if (cmd.log_sel)
					ld_q <= {e_q, frac_q};
				else
					ln_q <= {e_q, frac_q};
			end
			OP_MAG: begin
				neg_q <= ld_q > ln_q;
				mag_q <= (ld_q > ln_q) ? ld_q - ln_q : ln_q - ld_q;
			end
			OP_IDF: idf_q <= idf_full[59:32];
			OP_LDIV_INIT: begin
				rem_q     <= '0;
				dvd_q     <= {len_q, 9'b0};
				divisor_q <= (avg_q == '0) ? 54'd1 : 54'(avg_q);
				quo_q     <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= q_bit ? 54'(rem_sh - {1'b0, divisor_q}) : rem_sh[53:0];
				dvd_q <= {dvd_q[27:0], 1'b0};
				quo_q <= {quo_q[27:0], q_bit};
			end
			OP_NORM: bq_q <= 37'(bc) * 37'(quo_q[19:0]);
			OP_DEN_MUL: begin
				kn_q <= 53'(k1_q) * 53'(norm);
				nm_q <= 33'(17'(k1_q) + K1_ONE_Q12) * 33'(tf_q);
			end
			OP_TDIV_INIT: begin
				// Quotient stays below 2^29, so start at the dividend shifted down 29
				divisor_q <= 54'(kn_q) + 54'({tf_q, 28'b0});
				rem_q     <= 54'({nm_q, 11'b0});
				dvd_q     <= '0;
				quo_q     <= '0;
			end
			OP_PROD:  prod_q <= 57'(idf_q) * 57'(quo_eff);
			OP_ROUND: term_q <= neg_q ? -signed'(s_mag) : signed'(s_mag);
			OP_ACC: ;
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/bm25_score_accumulator_core.sv
// Top level of the BM25 score accumulator: sequencer plus datapath.
// Depends on bm25_pkg, bm25_ctrl and bm25_dpath.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------------
//   input    | in_valid/in_ready   | term_freq, doc_length, doc_freq, term_present,
//            |                     | last_term
//   result   | out_valid/out_ready | total_score, saturated
//   config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A present term holds in_ready low until its score is added, so a new request waits
// through two 24-step log2 squaring passes, a 20-step length divide and a 29-step tf
// divide on one shared restoring divider. The last term of a document then passes
// through the finish state, which loads the result register and stalls while an
// earlier result waits. An absent term leaves in_ready high unless it is the last.
// A result sits in its output register; new requests are taken while it waits.
// Reset is asynchronous; it loads the register defaults and clears the sum.
module bm25_score_accumulator_core
	import bm25_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           term_freq,
	input  logic [19:0]           doc_length,
	input  logic [23:0]           doc_freq,
	input  logic                  term_present,
	input  logic                  last_term,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    total_score,
	output logic                  saturated,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	bm25_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.term_present (term_present),
		.last_term    (last_term),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cmd          (cmd)
	);

	bm25_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.term_freq   (term_freq),
		.doc_length  (doc_length),
		.doc_freq    (doc_freq),
		.total_score (total_score),
		.saturated   (saturated)
	);

`ifndef SYNTHESIS
	// A taken request that starts work blocks the next one from being taken back to back
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (term_present || last_term)) |=> !in_ready)
		else $error("request taken twice back to back");

	// A result is dropped only when taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result lost before it was taken");

	// The result register stays put while it waits
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(total_score) && $stable(saturated)))
		else $error("result changed while waiting");
`endif

endmodule
